// ----- hw/rtl/generation_tagged_handle_table_unit_defines.svh -----
// Assertion macros for the generation-tagged handle table unit.
// Used by the top level only; no other dependencies.
`ifndef GENERATION_TAGGED_HANDLE_TABLE_UNIT_DEFINES_SVH
`define GENERATION_TAGGED_HANDLE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define HTU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("handle table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define HTU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("handle table: next-cycle check failed");

`endif

// ----- hw/rtl/htu_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the handle table unit.
// No dependencies; every other file but the macro header refers to it by scoped names.
package htu_pkg;

   // Table geometry
   localparam int SLOT_COUNT = 64;
   localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

   // Field widths
   localparam int GEN_W      = 32;
   localparam int IDX_W      = 32;
   localparam int HANDLE_W   = GEN_W + IDX_W;
   localparam int CMD_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_NUM_W = 6;

   typedef enum logic [CMD_W-1:0] {
      OP_ALLOC       = 2'd0,
      OP_CHECK       = 2'd1,
      OP_RELEASE     = 2'd2,
      OP_RELEASE_ALL = 2'd3
   } htu_op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_STALE   = 2'd2,
      ST_FULL    = 2'd3
   } htu_status_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;      // request taken this cycle
      logic sweep_step;  // one step of the release-all generation sweep
      logic commit;      // update state and load the response register
   } htu_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_all;     // incoming request is release-all
      logic sweep_last;  // this sweep step writes the last slot
      logic out_free;    // response register can take a new response
   } htu_stat_type;

   // Advance a generation by one, skipping zero on wrap
   function automatic logic [GEN_W-1:0] next_generation(input logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] n;
      n = g + GEN_W'(1);
      if (n == '0) begin
         n = GEN_W'(1);
      end
      return n;
   endfunction

   // Index of the lowest free slot (zero when none is free)
   function automatic logic [SLOT_W-1:0] first_free(input logic [SLOT_COUNT-1:0] in_use);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!in_use[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ----- hw/rtl/htu_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and responses.
// Depends on htu_pkg for field widths.

// Request channel: command and handle
interface htu_req_if;
   logic                          valid;
   logic                          ready;
   logic [htu_pkg::CMD_W-1:0]     command;
   logic [htu_pkg::HANDLE_W-1:0]  handle;

   modport source (output valid, output command, output handle, input ready);
   modport sink   (input valid, input command, input handle, output ready);
endinterface

// Response channel: status, granted handle and slot number
interface htu_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [htu_pkg::STATUS_W-1:0]    status;
   logic [htu_pkg::HANDLE_W-1:0]    new_handle;
   logic [htu_pkg::SLOT_NUM_W-1:0]  slot_number;

   modport source (output valid, output status, output new_handle, output slot_number,
                   input ready);
   modport sink   (input valid, input status, input new_handle, input slot_number,
                   output ready);
endinterface

// ----- hw/rtl/htu_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer of the handle table unit: accept, sweep and commit phases.
// Depends on htu_pkg for the command and status structs.
module htu_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  htu_pkg::htu_stat_type dp_stat,
   output htu_pkg::htu_cmd_type  dp_cmd
);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_SWEEP = 3'b010,
      S_EVAL  = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in          = state_ff;
      req_ready         = 1'b0;
      dp_cmd.accept     = 1'b0;
      dp_cmd.sweep_step = 1'b0;
      dp_cmd.commit     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            dp_cmd.accept = req_valid;
            if (req_valid) begin
               state_in = dp_stat.req_all ? S_SWEEP : S_EVAL;
            end
         end
         S_SWEEP: begin
            dp_cmd.sweep_step = 1'b1;
            if (dp_stat.sweep_last) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            // hold until the response register is free
            dp_cmd.commit = dp_stat.out_free;
            if (dp_stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/htu_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the handle table unit: slot flags, generation memory,
// handle decode and the response register. Depends on htu_pkg.
module htu_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  htu_pkg::htu_cmd_type            ctrl_cmd,
   output htu_pkg::htu_stat_type           ctrl_stat,
   input  logic [htu_pkg::CMD_W-1:0]       req_command,
   input  logic [htu_pkg::HANDLE_W-1:0]    req_handle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [htu_pkg::STATUS_W-1:0]    rsp_status,
   output logic [htu_pkg::HANDLE_W-1:0]    rsp_new_handle,
   output logic [htu_pkg::SLOT_NUM_W-1:0]  rsp_slot_number
);

   // Generation memory and its registered read port
   logic [htu_pkg::GEN_W-1:0]      gen_mem [htu_pkg::SLOT_COUNT];
   logic [htu_pkg::GEN_W-1:0]      gen_rd_ff;
   logic                           gen_rd_ok_ff;

   // Slot flags: in use, and generation written since reset
   logic [htu_pkg::SLOT_COUNT-1:0] in_use_ff, in_use_in;
   logic [htu_pkg::SLOT_COUNT-1:0] written_ff, written_in;

   // Request held for the commit phase
   htu_pkg::htu_op_type            op_ff, op_in;
   logic [htu_pkg::GEN_W-1:0]      hgen_ff, hgen_in;
   logic                           bad_ff, bad_in;
   logic                           full_ff, full_in;
   logic [htu_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic                           use_rd_ff, use_rd_in;
   logic [htu_pkg::CNT_W-1:0]      cnt_ff, cnt_in;

   // Response register
   logic                            rsp_valid_ff, rsp_valid_in;
   htu_pkg::htu_status_type         status_ff, status_in;
   logic [htu_pkg::HANDLE_W-1:0]    nhandle_ff, nhandle_in;
   logic [htu_pkg::SLOT_NUM_W-1:0]  slotnum_ff, slotnum_in;

   htu_pkg::htu_op_type            req_op;
   logic [htu_pkg::IDX_W-1:0]      req_idx;
   logic [htu_pkg::GEN_W-1:0]      req_gen;
   logic [htu_pkg::SLOT_W-1:0]     req_slot;
   logic [htu_pkg::SLOT_W-1:0]     free_idx;
   logic [htu_pkg::GEN_W-1:0]      gen_eff;
   logic [htu_pkg::GEN_W-1:0]      gen_next;
   logic                           rd_en;
   logic [htu_pkg::SLOT_W-1:0]     rd_addr;
   logic                           wr_en;
   logic [htu_pkg::SLOT_W-1:0]     wr_addr;
   logic                           out_free;

   // Request decode
   assign req_op   = htu_pkg::htu_op_type'(req_command);
   assign req_idx  = req_handle[htu_pkg::IDX_W-1:0];
   assign req_gen  = req_handle[htu_pkg::HANDLE_W-1:htu_pkg::IDX_W];
   assign req_slot = htu_pkg::SLOT_W'(req_idx - htu_pkg::IDX_W'(1));
   assign free_idx = htu_pkg::first_free(in_use_ff);

   // A never-written generation reads as zero
   assign gen_eff  = gen_rd_ok_ff ? gen_rd_ff : '0;
   assign gen_next = htu_pkg::next_generation(gen_eff);

   assign out_free = !rsp_valid_ff || rsp_ready;

   assign ctrl_stat.req_all    = (req_op == htu_pkg::OP_RELEASE_ALL);
   assign ctrl_stat.sweep_last = (cnt_ff == htu_pkg::CNT_W'(htu_pkg::SLOT_COUNT));
   assign ctrl_stat.out_free   = out_free;

   // Memory read address: sweep pointer, or the slot the request names
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (ctrl_cmd.sweep_step) begin
         rd_en   = (cnt_ff < htu_pkg::CNT_W'(htu_pkg::SLOT_COUNT));
         rd_addr = htu_pkg::SLOT_W'(cnt_ff);
      end else if (ctrl_cmd.accept) begin
         rd_en = 1'b1;
         case (req_op) inside
            htu_pkg::OP_ALLOC:                        rd_addr = free_idx;
            htu_pkg::OP_CHECK, htu_pkg::OP_RELEASE:   rd_addr = req_slot;
            default:                                  rd_addr = '0;
         endcase
      end
   end

   // Memory write: one sweep entry, or the slot an allocate grants
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = slot_ff;
      if (ctrl_cmd.sweep_step) begin
         wr_en   = 1'b1;
         wr_addr = htu_pkg::SLOT_W'(cnt_ff - htu_pkg::CNT_W'(1));
      end else if (ctrl_cmd.commit && op_ff == htu_pkg::OP_ALLOC && !full_ff) begin
         wr_en = 1'b1;
      end
   end

   // Generation memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         gen_mem[wr_addr] <= gen_next;
      end
      if (rd_en) begin
         gen_rd_ff    <= gen_mem[rd_addr];
         gen_rd_ok_ff <= written_ff[rd_addr];
      end
   end

   // Latch the request and its decode on accept
   always_comb begin
      op_in     = op_ff;
      hgen_in   = hgen_ff;
      bad_in    = bad_ff;
      full_in   = full_ff;
      slot_in   = slot_ff;
      use_rd_in = use_rd_ff;
      cnt_in    = cnt_ff;
      if (ctrl_cmd.accept) begin
         op_in     = req_op;
         hgen_in   = req_gen;
         bad_in    = (req_idx == '0) || (req_gen == '0) ||
                     (req_idx > htu_pkg::IDX_W'(htu_pkg::SLOT_COUNT));
         full_in   = &in_use_ff;
         slot_in   = (req_op == htu_pkg::OP_ALLOC) ? free_idx : req_slot;
         use_rd_in = in_use_ff[req_slot];
         cnt_in    = htu_pkg::CNT_W'(1);
      end else if (ctrl_cmd.sweep_step) begin
         cnt_in = htu_pkg::CNT_W'(cnt_ff + htu_pkg::CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      hgen_ff   <= hgen_in;
      bad_ff    <= bad_in;
      full_ff   <= full_in;
      slot_ff   <= slot_in;
      use_rd_ff <= use_rd_in;
      cnt_ff    <= cnt_in;
   end

   // Commit: slot flags and the response
   always_comb begin
      in_use_in    = in_use_ff;
      written_in   = written_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      status_in    = status_ff;
      nhandle_in   = nhandle_ff;
      slotnum_in   = slotnum_ff;
      if (wr_en) begin
         written_in[wr_addr] = 1'b1;
      end
      if (ctrl_cmd.commit) begin
         rsp_valid_in = 1'b1;
         status_in    = htu_pkg::ST_OK;
         nhandle_in   = '0;
         slotnum_in   = '0;
         case (op_ff) inside
            htu_pkg::OP_ALLOC: begin
               if (full_ff) begin
                  status_in = htu_pkg::ST_FULL;
               end else begin
                  in_use_in[slot_ff] = 1'b1;
                  nhandle_in = {gen_next,
                                htu_pkg::IDX_W'(slot_ff) + htu_pkg::IDX_W'(1)};
                  slotnum_in = htu_pkg::SLOT_NUM_W'(slot_ff);
               end
            end
            htu_pkg::OP_CHECK, htu_pkg::OP_RELEASE: begin
               if (bad_ff) begin
                  status_in = htu_pkg::ST_INVALID;
               end else begin
                  slotnum_in = htu_pkg::SLOT_NUM_W'(slot_ff);
                  if (use_rd_ff && gen_eff == hgen_ff) begin
                     if (op_ff == htu_pkg::OP_RELEASE) begin
                        in_use_in[slot_ff] = 1'b0;
                     end
                  end else begin
                     status_in = htu_pkg::ST_STALE;
                  end
               end
            end
            default: begin
               // release-all: generations were advanced by the sweep
               in_use_in = '0;
            end
         endcase
      end
   end

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff    <= '0;
         written_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_use_ff    <= in_use_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      nhandle_ff <= nhandle_in;
      slotnum_ff <= slotnum_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_new_handle  = nhandle_ff;
   assign rsp_slot_number = slotnum_ff;

endmodule

// ----- hw/rtl/generation_tagged_handle_table_unit.sv -----
`timescale 1ns / 1ps
// Top level of the generation-tagged handle table unit.
// Depends on htu_pkg, htu_if, htu_ctrl, htu_dp and the assertion macro header.

// The unit serves one request at a time. For allocate, check and release,
// the accept cycle reads the slot's generation from the generation memory,
// and the evaluation state, once the response register is free, updates
// the slot and loads the response register. Release-all first runs a sweep
// that reads and rewrites every generation through that memory's one write
// port. The response register lets a new request enter while the previous
// response waits; a request finishes only once that register is free.
// Reset needs no clearing pass: per-slot written flags make untouched
// generations read as zero.

`include "generation_tagged_handle_table_unit_defines.svh"

module generation_tagged_handle_table_unit (
   input  logic  clock,
   input  logic  reset,
   htu_req_if.sink   req_chan,
   htu_rsp_if.source rsp_chan
);

   htu_pkg::htu_cmd_type  ctrl_cmd;
   htu_pkg::htu_stat_type dp_stat;

   // Sequencer
   htu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (ctrl_cmd)
   );

   // Table storage and response register
   htu_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctrl_cmd        (ctrl_cmd),
      .ctrl_stat       (dp_stat),
      .req_command     (req_chan.command),
      .req_handle      (req_chan.handle),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_new_handle  (rsp_chan.new_handle),
      .rsp_slot_number (rsp_chan.slot_number)
   );

   // Checks
   `HTU_ASSERT_IMPLY(a_commit_free, clock, reset, ctrl_cmd.commit, dp_stat.out_free)
   `HTU_ASSERT_NEXT(a_commit_rsp, clock, reset, ctrl_cmd.commit, rsp_chan.valid)
   `HTU_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready)
   `HTU_ASSERT_IMPLY(a_sweep_busy, clock, reset, ctrl_cmd.sweep_step, !req_chan.ready && !ctrl_cmd.commit)

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the generation-tagged handle table unit.
// Depends on htu_pkg and the htu_req_if / htu_rsp_if channel interfaces.

module tb_top;

   localparam int PENDING_DEPTH = 4;     // generator runs at most this far ahead
   localparam int RANDOM_ITEMS  = 1500;
   localparam int LONG_HOLD     = 300;   // receiver hold-off to back up the unit
   localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int DRAIN_CYCLES  = 80;    // release-all sweep plus margin
   localparam int POOL_DEPTH    = 96;
   localparam int PRINT_LIMIT   = 40;

   typedef struct packed {
      htu_pkg::htu_op_type                 cmd;
      logic [htu_pkg::HANDLE_W-1:0]        handle;
   } handle_request_type;

   typedef struct packed {
      htu_pkg::htu_status_type             status;
      logic [htu_pkg::HANDLE_W-1:0]        new_handle;
      logic [htu_pkg::SLOT_NUM_W-1:0]      slot_number;
   } handle_reply_type;

   logic clock;
   logic reset;

   htu_req_if req_bus ();
   htu_rsp_if rsp_bus ();

   generation_tagged_handle_table_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the slot table
   logic                      slot_busy [htu_pkg::SLOT_COUNT];
   logic [htu_pkg::GEN_W-1:0] slot_gen  [htu_pkg::SLOT_COUNT];

   handle_request_type           pending_requests [$];
   handle_reply_type             expected_replies [$];
   logic [htu_pkg::HANDLE_W-1:0] granted_handles  [$];

   int   items_queued   = 0;
   int   mismatch_count = 0;
   int   stall_asked    = 0;
   int   stall_served   = 0;
   logic no_idle        = 1'b0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Generation advance: +1 with wrap, zero is skipped
   function automatic logic [htu_pkg::GEN_W-1:0] bump_gen(input logic [htu_pkg::GEN_W-1:0] g);
      logic [htu_pkg::GEN_W-1:0] n;
      n = g + htu_pkg::GEN_W'(1);
      if (n == '0) begin
         n = htu_pkg::GEN_W'(1);
      end
      return n;
   endfunction

   // Apply one accepted request to the shadow table and return its reply
   function automatic handle_reply_type apply_to_table(input handle_request_type rq);
      handle_reply_type          rp;
      logic [htu_pkg::GEN_W-1:0] gen;
      logic [htu_pkg::IDX_W-1:0] idx;
      logic                      found;
      rp.status      = htu_pkg::ST_OK;
      rp.new_handle  = '0;
      rp.slot_number = '0;
      found          = 1'b0;
      gen = rq.handle[htu_pkg::HANDLE_W-1:htu_pkg::IDX_W];
      idx = rq.handle[htu_pkg::IDX_W-1:0];
      case (rq.cmd) inside
         htu_pkg::OP_ALLOC: begin
            rp.status = htu_pkg::ST_FULL;
            for (int s = 0; s < htu_pkg::SLOT_COUNT; s++) begin
               if (!found && !slot_busy[s]) begin
                  found          = 1'b1;
                  slot_gen[s]    = bump_gen(slot_gen[s]);
                  slot_busy[s]   = 1'b1;
                  rp.status      = htu_pkg::ST_OK;
                  rp.new_handle  = {slot_gen[s], htu_pkg::IDX_W'(s + 1)};
                  rp.slot_number = htu_pkg::SLOT_NUM_W'(s);
               end
            end
            if (found) begin
               granted_handles.push_back(rp.new_handle);
               if (granted_handles.size() > POOL_DEPTH) begin
                  void'(granted_handles.pop_front());
               end
            end
         end
         htu_pkg::OP_CHECK, htu_pkg::OP_RELEASE: begin
            // zero handle falls under the zero index test
            if (idx == '0 || idx > htu_pkg::IDX_W'(htu_pkg::SLOT_COUNT) || gen == '0) begin
               rp.status = htu_pkg::ST_INVALID;
            end else begin
               rp.slot_number = htu_pkg::SLOT_NUM_W'(idx - 1);
               if (!slot_busy[idx - 1] || slot_gen[idx - 1] != gen) begin
                  rp.status = htu_pkg::ST_STALE;
               end else if (rq.cmd == htu_pkg::OP_RELEASE) begin
                  slot_busy[idx - 1] = 1'b0;
               end
            end
         end
         default: begin
            for (int s = 0; s < htu_pkg::SLOT_COUNT; s++) begin
               slot_busy[s] = 1'b0;
               slot_gen[s]  = bump_gen(slot_gen[s]);
            end
         end
      endcase
      return rp;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [htu_pkg::HANDLE_W-1:0] got,
                                  input logic [htu_pkg::HANDLE_W-1:0] want);
      if (mismatch_count < PRINT_LIMIT) begin
         $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Request driver: pops pending requests, idles in random bursts
   always @(posedge clock) begin : request_driver
      handle_request_type on_bus;
      handle_request_type item;
      int                 gap_left;
      logic               send;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
         for (int s = 0; s < htu_pkg::SLOT_COUNT; s++) begin
            slot_busy[s] = 1'b0;
            slot_gen[s]  = '0;
         end
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_replies.push_back(apply_to_table(on_bus));
         end
         if (!req_bus.valid || req_bus.ready) begin
            send = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (!no_idle && $urandom_range(0, 11) == 0) begin
               gap_left = $urandom_range(0, 17);
            end else if (pending_requests.size() > 0) begin
               item   = pending_requests.pop_front();
               on_bus = item;
               send   = 1'b1;
               req_bus.command <= item.cmd;
               req_bus.handle  <= item.handle;
            end
            req_bus.valid <= send;
         end
      end
   end

   // Reply monitor: compares with the oldest expectation, owns rsp ready
   always @(posedge clock) begin : reply_monitor
      handle_reply_type want;
      int               hold_left;
      logic             take;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("reply with no request outstanding", rsp_bus.new_handle, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_bus.status !== want.status) begin
                  report_mismatch("status", htu_pkg::HANDLE_W'(rsp_bus.status),
                                  htu_pkg::HANDLE_W'(want.status));
               end
               if (rsp_bus.new_handle !== want.new_handle) begin
                  report_mismatch("new_handle", rsp_bus.new_handle, want.new_handle);
               end
               if (rsp_bus.slot_number !== want.slot_number) begin
                  report_mismatch("slot_number", htu_pkg::HANDLE_W'(rsp_bus.slot_number),
                                  htu_pkg::HANDLE_W'(want.slot_number));
               end
            end
         end
         if (stall_served != stall_asked) begin
            stall_served++;
            hold_left = LONG_HOLD;
         end
         take = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
         end else if (!no_idle && $urandom_range(0, 11) == 0) begin
            hold_left = $urandom_range(0, 17);
         end else begin
            take = 1'b1;
         end
         rsp_bus.ready <= take;
      end
   end

   // Watchdog: ends the run when no handshake happens for too long
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   task automatic queue_request(input htu_pkg::htu_op_type cmd,
                                input logic [htu_pkg::HANDLE_W-1:0] handle);
      handle_request_type rq;
      while (pending_requests.size() >= PENDING_DEPTH) begin
         @(negedge clock);
      end
      rq.cmd    = cmd;
      rq.handle = handle;
      pending_requests.push_back(rq);
      items_queued++;
   endtask

   // Sender pause: wait until every request has been answered
   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || req_bus.valid || expected_replies.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // A recently granted handle, or a plausible one before any grant
   function automatic logic [htu_pkg::HANDLE_W-1:0] pick_granted();
      if (granted_handles.size() == 0) begin
         return {htu_pkg::GEN_W'($urandom_range(1, 4)),
                 htu_pkg::IDX_W'($urandom_range(1, htu_pkg::SLOT_COUNT))};
      end
      return granted_handles[$urandom_range(0, granted_handles.size() - 1)];
   endfunction

   // A granted handle with one field damaged
   function automatic logic [htu_pkg::HANDLE_W-1:0] damage_handle(
         input logic [htu_pkg::HANDLE_W-1:0] h);
      logic [htu_pkg::GEN_W-1:0] gen;
      logic [htu_pkg::IDX_W-1:0] idx;
      gen = h[htu_pkg::HANDLE_W-1:htu_pkg::IDX_W];
      idx = h[htu_pkg::IDX_W-1:0];
      case ($urandom_range(0, 5))
         0: gen = gen + htu_pkg::GEN_W'(1);
         1: gen = gen - htu_pkg::GEN_W'(1);
         2: gen = '0;
         3: idx = '0;
         4: idx = ($urandom_range(0, 1) == 0) ? htu_pkg::IDX_W'(htu_pkg::SLOT_COUNT + 1)
                                              : htu_pkg::IDX_W'($urandom);
         default: idx = htu_pkg::IDX_W'($urandom_range(1, htu_pkg::SLOT_COUNT));
      endcase
      return {gen, idx};
   endfunction

   // Stimulus
   initial begin : stimulus
      int   pick;
      logic hold_one, hold_two, paused;
      reset    = 1'b1;
      hold_one = 1'b0;
      hold_two = 1'b0;
      paused   = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: invalid forms, stale forms, grant, release, release-all
      queue_request(htu_pkg::OP_CHECK, '0);                            // zero handle
      queue_request(htu_pkg::OP_RELEASE, '0);
      queue_request(htu_pkg::OP_ALLOC, '1);                            // handle ignored
      queue_request(htu_pkg::OP_CHECK, 64'h0000_0001_0000_0001);       // ok
      queue_request(htu_pkg::OP_CHECK, 64'h0000_0000_0000_0001);       // zero generation
      queue_request(htu_pkg::OP_CHECK, 64'h0000_0001_0000_0000);       // index zero
      queue_request(htu_pkg::OP_CHECK,
                    {32'd1, htu_pkg::IDX_W'(htu_pkg::SLOT_COUNT + 1)}); // index past end
      queue_request(htu_pkg::OP_CHECK, '1);
      queue_request(htu_pkg::OP_CHECK, 64'h0000_0002_0000_0001);       // generation mismatch
      queue_request(htu_pkg::OP_CHECK, 64'h0000_0001_0000_0002);       // slot free
      queue_request(htu_pkg::OP_CHECK,
                    {32'd1, htu_pkg::IDX_W'(htu_pkg::SLOT_COUNT)});     // last slot, free
      queue_request(htu_pkg::OP_RELEASE, 64'hffff_ffff_ffff_ffff);
      queue_request(htu_pkg::OP_RELEASE, 64'h0000_0001_0000_0001);     // ok
      queue_request(htu_pkg::OP_RELEASE, 64'h0000_0001_0000_0001);     // now stale
      queue_request(htu_pkg::OP_ALLOC, '0);
      queue_request(htu_pkg::OP_RELEASE_ALL, '1);
      queue_request(htu_pkg::OP_CHECK, 64'h0000_0002_0000_0001);       // stale after sweep
      queue_request(htu_pkg::OP_ALLOC, '0);
      queue_request(htu_pkg::OP_ALLOC, '0);
      queue_request(htu_pkg::OP_RELEASE_ALL, '0);

      // Fill past full once so the last slot and the full status show up
      repeat (htu_pkg::SLOT_COUNT + 3) queue_request(htu_pkg::OP_ALLOC, {$urandom, $urandom});

      while (items_queued < RANDOM_ITEMS) begin
         if (!hold_one && items_queued >= 400) begin
            hold_one = 1'b1;
            stall_asked++;
         end
         if (!paused && items_queued >= 800) begin
            paused = 1'b1;
            wait_for_drain();
         end
         if (!hold_two && items_queued >= 1000) begin
            hold_two = 1'b1;
            stall_asked++;
         end
         if (items_queued >= 1350) begin
            no_idle = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            repeat ($urandom_range(8, 70))
               queue_request(htu_pkg::OP_ALLOC, {$urandom, $urandom});
         end else if (pick < 30) begin
            queue_request(htu_pkg::OP_ALLOC, '0);
         end else if (pick < 50) begin
            queue_request(htu_pkg::OP_CHECK, pick_granted());
         end else if (pick < 68) begin
            queue_request(htu_pkg::OP_RELEASE, pick_granted());
         end else if (pick < 80) begin
            queue_request(($urandom_range(0, 1) == 0) ? htu_pkg::OP_CHECK : htu_pkg::OP_RELEASE,
                          damage_handle(pick_granted()));
         end else if (pick < 83) begin
            queue_request(htu_pkg::OP_RELEASE_ALL, {$urandom, $urandom});
         end else if (pick < 88) begin
            repeat ($urandom_range(1, 12)) queue_request(htu_pkg::OP_RELEASE, pick_granted());
         end else if (pick < 94) begin
            queue_request(htu_pkg::htu_op_type'($urandom_range(0, 2)), {$urandom, $urandom});
         end else begin
            queue_request(htu_pkg::htu_op_type'($urandom_range(1, 2)),
                          {$urandom,
                           htu_pkg::IDX_W'($urandom_range(0, htu_pkg::SLOT_COUNT + 2))});
         end
      end

      // All stimulus out: wait for the last replies, then for stragglers
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
